[rtl/ssnp_pkg.sv]
// Shared types, constants and helper functions for the stereo tone/noise synth.
// Used by every module of the block; has no dependencies of its own.
`timescale 1ns / 1ps
`default_nettype none

package ssnp_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned SINE_DEPTH_DEF  = 1024;
  localparam int unsigned SAMPLE_BITS_DEF = 16;

  // Fixed field widths and internal sizes
  localparam int unsigned FIELD_W     = 16;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned APB_AW      = 4;

  // Register map, index = paddr[3:2]
  localparam logic [1:0] REG_VOLUME = 2'd0;
  localparam logic [1:0] REG_PAN    = 2'd1;
  localparam logic [1:0] REG_TARGET = 2'd2;
  localparam logic [1:0] REG_NOISE  = 2'd3;

  // Register reset values
  localparam logic [15:0] VOLUME_RST = 16'd3277;
  localparam logic [16:0] PAN_RST    = 17'd32768;

  // Arithmetic constants
  localparam logic [11:0] GLIDE_Q16   = 12'd3277;   // 0.05 in Q0.16
  localparam logic [16:0] PAN_FULL    = 17'd65536;
  localparam logic [31:0] LFSR_MASK   = 32'h8020_0003;
  localparam logic [31:0] LFSR_SEED   = 32'd1;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // Configuration as seen by the back end
  typedef struct packed {
    logic [15:0] volume;
    logic [16:0] pan;
    logic [31:0] target;
  } cfg_t;

  // Classified work word passed through the queue
  typedef struct packed {
    logic glide;  // apply increment glide before the phase step
    logic noise;  // draw two noise values instead of a sine lookup
  } cmd_t;

  // Raw Q1.15 value pair before gain and pan
  typedef struct packed {
    logic signed [15:0] right;
    logic signed [15:0] left;
  } pair_t;

  // Advance the Galois LFSR by eight shifts
  function automatic logic [31:0] lfsr_adv8(input logic [31:0] s);
    logic [31:0] v;
    v = s;
    for (int i = 0; i < 8; i++) begin
      v = (v >> 1) ^ (v[0] ? LFSR_MASK : 32'd0);
    end
    return v;
  endfunction

  // Q1.15 sine of phase p (2^32 = full turn), Taylor series to x^13
  function automatic logic signed [15:0] sine_q15(input logic [31:0] p);
    logic [63:0] r;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] res;
    r = {34'd0, p[29:0]};
    if (p[30]) begin
      r = 64'h4000_0000 - r;
    end
    x    = (r * HALF_PI_Q30) >> 30;
    x2   = (x * x) >> 30;
    term = x;
    sum  = x;
    term = ((term * x2) >> 30) / 64'd6;
    sum  = sum - term;
    term = ((term * x2) >> 30) / 64'd20;
    sum  = sum + term;
    term = ((term * x2) >> 30) / 64'd42;
    sum  = sum - term;
    term = ((term * x2) >> 30) / 64'd72;
    sum  = sum + term;
    term = ((term * x2) >> 30) / 64'd110;
    sum  = sum - term;
    term = ((term * x2) >> 30) / 64'd156;
    sum  = sum + term;
    res  = (sum * 64'd32767 + 64'h2000_0000) >> 30;
    if (res > 64'd32767) begin
      res = 64'd32767;
    end
    return p[31] ? 16'(64'd0 - res) : res[15:0];
  endfunction

endpackage

`default_nettype wire

[rtl/ssnp_front.sv]
// Front end: APB register file and input word classification.
// Depends on ssnp_pkg; feeds ssnp_queue with cmd_t words.
`timescale 1ns / 1ps
`default_nettype none

module ssnp_front (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [ssnp_pkg::APB_AW-1:0]   paddr,
  input  wire logic [31:0]                   pwdata,
  output      logic [31:0]                   prdata,
  output      logic                          pready,
  input  wire logic                          s_tvalid,
  output      logic                          s_tready,
  input  wire logic                          buffer_start,
  output      logic                          push,
  output      ssnp_pkg::cmd_t                push_cmd,
  input  wire logic                          push_ready,
  output      ssnp_pkg::cfg_t                cfg
);
  import ssnp_pkg::*;

  logic [15:0] volume;
  logic [16:0] pan;
  logic [31:0] target_increment;
  logic        noise_mode;
  logic [1:0]  reg_idx;
  logic        wr_en;

  assign reg_idx = paddr[3:2];
  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;

  // Write registers on the access cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      volume           <= VOLUME_RST;
      pan              <= PAN_RST;
      target_increment <= 32'd0;
      noise_mode       <= 1'b0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_VOLUME: volume           <= pwdata[15:0];
        REG_PAN:    pan              <= pwdata[16:0];
        REG_TARGET: target_increment <= pwdata;
        REG_NOISE:  noise_mode       <= pwdata[0];
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (reg_idx)
      REG_VOLUME: prdata = {16'd0, volume};
      REG_PAN:    prdata = {15'd0, pan};
      REG_TARGET: prdata = target_increment;
      REG_NOISE:  prdata = {31'd0, noise_mode};
    endcase
  end

  // Classify: glide applies only in tone mode
  assign s_tready       = push_ready;
  assign push           = s_tvalid & push_ready;
  assign push_cmd.noise = noise_mode;
  assign push_cmd.glide = buffer_start & ~noise_mode;

  assign cfg.volume = volume;
  assign cfg.pan    = pan;
  assign cfg.target = target_increment;

endmodule

`default_nettype wire

[rtl/ssnp_queue.sv]
// Small FIFO of classified words between front end and generator.
// Depends on ssnp_pkg for cmd_t.
`timescale 1ns / 1ps
`default_nettype none

module ssnp_queue #(
  parameter int unsigned DEPTH = ssnp_pkg::QUEUE_DEPTH
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  input  wire ssnp_pkg::cmd_t in_cmd,
  output      logic           in_ready,
  output      logic           out_valid,
  output      ssnp_pkg::cmd_t out_cmd,
  input  wire logic           out_ready
);
  import ssnp_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

  cmd_t          slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_wr;
  logic          do_rd;

  assign in_ready  = (count != CW'(DEPTH));
  assign out_valid = (count != '0);
  assign out_cmd   = slots[rd_ptr];
  assign do_wr     = in_valid & in_ready;
  assign do_rd     = out_valid & out_ready;

  // Store word
  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= in_cmd;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/ssnp_gen.sv]
// Back end, first half: glide, phase accumulator, sine ROM and noise LFSR.
// Depends on ssnp_pkg; pops cmd_t words and hands pair_t values to ssnp_scale.
`timescale 1ns / 1ps
`default_nettype none

module ssnp_gen #(
  parameter int unsigned SINE_TABLE_DEPTH = ssnp_pkg::SINE_DEPTH_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            q_valid,
  input  wire ssnp_pkg::cmd_t  q_cmd,
  output      logic            q_ready,
  input  wire logic [31:0]     target,
  output      logic            smp_valid,
  output      ssnp_pkg::pair_t smp,
  input  wire logic            smp_ready
);
  import ssnp_pkg::*;

  localparam int unsigned IDX_BITS = (SINE_TABLE_DEPTH > 1) ? $clog2(SINE_TABLE_DEPTH) : 1;
  localparam int unsigned ROM_W    = SINE_TABLE_DEPTH * 16;

  // Build the sine table at elaboration, entry k in bits [16k +: 16]
  function automatic logic [ROM_W-1:0] build_rom();
    logic [ROM_W-1:0] t;
    t = '0;
    for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
      t[k*16 +: 16] = sine_q15(32'((64'(k) << 32) / SINE_TABLE_DEPTH));
    end
    return t;
  endfunction

  localparam logic [ROM_W-1:0] SINE_ROM = build_rom();

  localparam logic [2:0] G_IDLE  = 3'd0;
  localparam logic [2:0] G_GMUL  = 3'd1;
  localparam logic [2:0] G_GADD  = 3'd2;
  localparam logic [2:0] G_PHASE = 3'd3;
  localparam logic [2:0] G_INDEX = 3'd4;
  localparam logic [2:0] G_ROM   = 3'd5;
  localparam logic [2:0] G_NOISE = 3'd6;
  localparam logic [2:0] G_OUT   = 3'd7;

  logic [2:0]          state;
  logic [31:0]         phase_acc;
  logic [31:0]         phase_step;
  logic [31:0]         noise_lfsr;
  logic [1:0]          cnt;
  logic                is_noise;
  logic [43:0]         glide_prod;
  logic                glide_neg;
  logic                glide_nz;
  logic [IDX_BITS-1:0] rom_idx;
  logic signed [15:0]  rom_q;
  logic signed [15:0]  smp_l;
  logic signed [15:0]  smp_r;

  logic [32:0] gap;
  logic [31:0] gap_mag;
  logic [43:0] glide_rnd;
  logic [27:0] glide_d;
  logic [63:0] idx_prod;
  logic [31:0] lfsr_nxt;

  // Glide magnitude and rounding
  always_comb begin
    gap       = {1'b0, target} - {1'b0, phase_step};
    gap_mag   = gap[32] ? 32'(~gap + 33'd1) : gap[31:0];
    glide_rnd = glide_prod + 44'd32768;
    glide_d   = glide_rnd[43:16];
    if (glide_d == '0 && glide_nz) begin
      glide_d = 28'd1;
    end
  end

  assign idx_prod = {32'd0, phase_acc} * 64'(SINE_TABLE_DEPTH);
  assign lfsr_nxt = lfsr_adv8(noise_lfsr);

  assign q_ready   = (state == G_IDLE);
  assign smp_valid = (state == G_OUT);
  assign smp.left  = is_noise ? smp_l : rom_q;
  assign smp.right = is_noise ? smp_r : rom_q;

  // Sequence one word at a time
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= G_IDLE;
      phase_acc  <= 32'd0;
      phase_step <= 32'd0;
      noise_lfsr <= LFSR_SEED;
      cnt        <= 2'd0;
    end else begin
      unique case (state)
        G_IDLE: begin
          cnt <= 2'd0;
          if (q_valid) begin
            priority if (q_cmd.noise) begin
              state <= G_NOISE;
            end else if (q_cmd.glide) begin
              state <= G_GMUL;
            end else begin
              state <= G_PHASE;
            end
          end
        end
        G_GMUL:  state <= G_GADD;
        G_GADD: begin
          phase_step <= glide_neg ? phase_step - 32'(glide_d) : phase_step + 32'(glide_d);
          state      <= G_PHASE;
        end
        G_PHASE: begin
          phase_acc <= phase_acc + phase_step;
          state     <= G_INDEX;
        end
        G_INDEX: state <= G_ROM;
        G_ROM:   state <= G_OUT;
        G_NOISE: begin
          noise_lfsr <= lfsr_nxt;
          cnt        <= cnt + 2'd1;
          if (cnt == 2'd3) begin
            state <= G_OUT;
          end
        end
        G_OUT: begin
          if (smp_ready) begin
            state <= G_IDLE;
          end
        end
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (state == G_IDLE && q_valid) begin
      is_noise <= q_cmd.noise;
    end
    if (state == G_GMUL) begin
      glide_prod <= 44'(gap_mag) * 44'(GLIDE_Q16);
      glide_neg  <= gap[32];
      glide_nz   <= (gap_mag != 32'd0);
    end
    if (state == G_INDEX) begin
      rom_idx <= idx_prod[32 +: IDX_BITS];
    end
    if (state == G_ROM) begin
      rom_q <= SINE_ROM[{rom_idx, 4'd0} +: 16];
    end
    if (state == G_NOISE && cnt == 2'd1) begin
      smp_l <= lfsr_nxt[15:0];
    end
    if (state == G_NOISE && cnt == 2'd3) begin
      smp_r <= lfsr_nxt[15:0];
    end
  end

endmodule

`default_nettype wire

[rtl/ssnp_scale.sv]
// Back end, second half: gain, pan law, rounding, saturation, output register.
// Depends on ssnp_pkg; drives the master stream of the top level.
`timescale 1ns / 1ps
`default_nettype none

module ssnp_scale #(
  parameter int unsigned SAMPLE_BITS = ssnp_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  input  wire ssnp_pkg::pair_t in_pair,
  output      logic            in_ready,
  input  wire logic [15:0]     volume,
  input  wire logic [16:0]     pan,
  output      logic            m_tvalid,
  input  wire logic            m_tready,
  output      logic [31:0]     m_tdata
);
  import ssnp_pkg::*;

  localparam int unsigned SH = 47 - SAMPLE_BITS;
  localparam logic [48:0] HALF    = 49'(1) << (SH - 1);
  localparam logic [48:0] LIM_NEG = 49'(1) << (SAMPLE_BITS - 1);
  localparam logic [48:0] LIM_POS = LIM_NEG - 49'd1;

  // Round magnitude, saturate, apply sign, cut to field width
  function automatic logic [FIELD_W-1:0] finish(input logic [48:0] pr, input logic neg);
    logic [48:0] q;
    q = (pr + HALF) >> SH;
    if (neg) begin
      if (q > LIM_NEG) begin
        q = LIM_NEG;
      end
      q = 49'd0 - q;
    end else if (q > LIM_POS) begin
      q = LIM_POS;
    end
    return q[FIELD_W-1:0];
  endfunction

  logic        en;
  logic        v1;
  logic        v2;
  logic [31:0] mv_l;
  logic [31:0] mv_r;
  logic        n1_l;
  logic        n1_r;
  logic [48:0] pr_l;
  logic [48:0] pr_r;
  logic        n2_l;
  logic        n2_r;
  logic [15:0] mag_l;
  logic [15:0] mag_r;
  logic [16:0] pan_c;
  logic [16:0] scale_l;
  logic [16:0] scale_r;

  assign en       = ~m_tvalid | m_tready;
  assign in_ready = en;

  // Magnitudes and clamped pan law
  assign mag_l   = in_pair.left[15]  ? 16'(~in_pair.left + 16'sd1)  : in_pair.left;
  assign mag_r   = in_pair.right[15] ? 16'(~in_pair.right + 16'sd1) : in_pair.right;
  assign pan_c   = (pan > PAN_FULL) ? PAN_FULL : pan;
  assign scale_l = PAN_FULL - pan_c;
  assign scale_r = pan_c;

  // Valid bits, stalled as one when the output word is held
  always_ff @(posedge clk) begin
    if (rst) begin
      v1       <= 1'b0;
      v2       <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (en) begin
      v1       <= in_valid;
      v2       <= v1;
      m_tvalid <= v2;
    end
  end

  // Gain, then pan, then round into the output word
  always_ff @(posedge clk) begin
    if (en) begin
      mv_l    <= 32'(mag_l) * 32'(volume);
      mv_r    <= 32'(mag_r) * 32'(volume);
      n1_l    <= in_pair.left[15];
      n1_r    <= in_pair.right[15];
      pr_l    <= 49'(mv_l) * 49'(scale_l);
      pr_r    <= 49'(mv_r) * 49'(scale_r);
      n2_l    <= n1_l;
      n2_r    <= n1_r;
      m_tdata <= {finish(pr_r, n2_r), finish(pr_l, n2_l)};
    end
  end

endmodule

`default_nettype wire

[rtl/stereo_sine_noise_synth_pan.sv]
// Top level of the stereo sine/noise synthesizer with glide and pan.
// Depends on ssnp_pkg, ssnp_front, ssnp_queue, ssnp_gen and ssnp_scale.
//
//   channel   dir   handshake                   payload
//   cfg       in    psel/penable/pwrite/pready  paddr[3:2] register, pwdata, prdata
//   s_*       in    s_tvalid/s_tready           s_tdata[0] buffer_start
//   m_*       out   m_tvalid/m_tready           s_tdata -> m_tdata {right, left}
//
// A tone word runs the generator sequencer through idle, phase step, ROM index,
// ROM read and output hand-off, with glide multiply and step update first when
// gliding; a noise word advances the LFSR 8 shifts per cycle, 32 shifts in all.
// Gain/pan registers the gain product, the pan product, then the output word.
// Reset is synchronous, active high, and clears registers, phase, step and LFSR.
// A stalled output holds the whole gain/pan pipeline; the 4-word queue takes words till full.
`timescale 1ns / 1ps
`default_nettype none

module stereo_sine_noise_synth_pan #(
  parameter int unsigned SINE_TABLE_DEPTH = ssnp_pkg::SINE_DEPTH_DEF,
  parameter int unsigned SAMPLE_BITS      = ssnp_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [ssnp_pkg::APB_AW-1:0] paddr,
  input  wire logic [31:0]                 pwdata,
  output      logic [31:0]                 prdata,
  output      logic                        pready,
  input  wire logic                        s_tvalid,
  output      logic                        s_tready,
  input  wire logic [7:0]                  s_tdata,   // [0] buffer_start, [7:1] zero
  output      logic                        m_tvalid,
  input  wire logic                        m_tready,
  output      logic [31:0]                 m_tdata    // [15:0] left_sample, [31:16] right_sample
);
  import ssnp_pkg::*;

  cfg_t  cfg;
  logic  push;
  cmd_t  push_cmd;
  logic  push_ready;
  logic  q_valid;
  cmd_t  q_cmd;
  logic  q_ready;
  logic  smp_valid;
  pair_t smp;
  logic  smp_ready;

  ssnp_front u_front (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .buffer_start (s_tdata[0]),
    .push         (push),
    .push_cmd     (push_cmd),
    .push_ready   (push_ready),
    .cfg          (cfg)
  );

  ssnp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (push),
    .in_cmd    (push_cmd),
    .in_ready  (push_ready),
    .out_valid (q_valid),
    .out_cmd   (q_cmd),
    .out_ready (q_ready)
  );

  ssnp_gen #(
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_gen (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_ready   (q_ready),
    .target    (cfg.target),
    .smp_valid (smp_valid),
    .smp       (smp),
    .smp_ready (smp_ready)
  );

  ssnp_scale #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_scale (
    .clk      (clk),
    .rst      (rst),
    .in_valid (smp_valid),
    .in_pair  (smp),
    .in_ready (smp_ready),
    .volume   (cfg.volume),
    .pan      (cfg.pan),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

`default_nettype wire

[rtl/ssnp_checker.sv]
// Port-level checker for the synthesizer top level, with its bind statement.
// Depends on ssnp_pkg for the address width; sees only the top-level ports.
`timescale 1ns / 1ps
`default_nettype none

module ssnp_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        psel,
  input wire logic                        penable,
  input wire logic                        pwrite,
  input wire logic [ssnp_pkg::APB_AW-1:0] paddr,
  input wire logic [31:0]                 pwdata,
  input wire logic [31:0]                 prdata,
  input wire logic                        pready,
  input wire logic                        s_tvalid,
  input wire logic                        s_tready,
  input wire logic [7:0]                  s_tdata,
  input wire logic                        m_tvalid,
  input wire logic                        m_tready,
  input wire logic [31:0]                 m_tdata
);
  import ssnp_pkg::*;

  logic [4:0] pending;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = s_tvalid & s_tready;
  assign out_acc = m_tvalid & m_tready;

  // Count words accepted but not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 5'd0;
    end else begin
      pending <= pending + 5'(in_acc) - 5'(out_acc);
    end
  end

  // A result word never appears without an accepted input word behind it
  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (pending != 5'd0))
    else $error("output word with no pending input word");

  // Reset empties the output side
  a_reset_clears: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  a_valid_holds: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("output valid dropped while stalled");

  a_data_holds: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata))
    else $error("output word changed while stalled");

endmodule

bind stereo_sine_noise_synth_pan ssnp_checker u_ssnp_checker (
  .clk      (clk),
  .rst      (rst),
  .psel     (psel),
  .penable  (penable),
  .pwrite   (pwrite),
  .paddr    (paddr),
  .pwdata   (pwdata),
  .prdata   (prdata),
  .pready   (pready),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire

[dv/synth_sample_checker.sv]
`timescale 1ns / 1ps
// Sample scoreboard for the stereo tone/noise synth: snoops register writes and
// both streams, predicts every stereo word and compares it on arrival.
// Depends on ssnp_pkg for the register map.

module synth_sample_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic                        pready,
  input  logic [ssnp_pkg::APB_AW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  input  logic                        s_tvalid,
  input  logic                        s_tready,
  input  logic [7:0]                  s_tdata,   // [0] buffer_start, [7:1] zero
  input  logic                        m_tvalid,
  input  logic                        m_tready,
  input  logic [31:0]                 m_tdata,   // [15:0] left_sample, [31:16] right_sample
  output int                          errors,
  output int                          outstanding
);
  import ssnp_pkg::*;

  localparam int          TABLE_BITS = 10;              // log2 of the sine table depth
  localparam logic [63:0] HALF_PI    = 64'd1686629713;  // pi/2 in Q2.30
  localparam logic [63:0] GLIDE_GAIN = 64'd3277;        // 0.05 in Q0.16
  localparam logic [31:0] NOISE_TAPS = 32'h8020_0003;
  localparam logic [16:0] FULL_RIGHT = 17'd65536;

  typedef struct packed {
    logic signed [15:0] right;
    logic signed [15:0] left;
  } stereo_t;

  // Shadow registers and oscillator state
  logic [15:0] vol_r;
  logic [16:0] pan_r;
  logic [31:0] target_r;
  logic        noise_r;
  logic [31:0] phase;
  logic [31:0] step;
  logic [31:0] lfsr;

  stereo_t expected_samples[$];
  stereo_t want;

  // Q1.15 sine of a phase, integer Taylor series to the x^13 term
  function automatic logic signed [15:0] tone_value(input logic [31:0] ph);
    logic [63:0] r;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] res;
    r = {34'd0, ph[29:0]};
    if (ph[30]) begin
      r = 64'h4000_0000 - r;
    end
    x    = (r * HALF_PI) >> 30;
    x2   = (x * x) >> 30;
    term = x;
    sum  = x;
    for (int n = 1; n <= 6; n++) begin
      term = ((term * x2) >> 30) / 64'(4 * n * n + 2 * n);
      sum  = n[0] ? sum - term : sum + term;
    end
    res = (sum * 64'd32767 + 64'h2000_0000) >> 30;
    if (res > 64'd32767) begin
      res = 64'd32767;
    end
    return ph[31] ? 16'(64'd0 - res) : res[15:0];
  endfunction

  // Advance the noise register 16 shifts and read its low half as Q1.15
  function automatic logic signed [15:0] next_noise();
    repeat (16) begin
      lfsr = (lfsr >> 1) ^ (lfsr[0] ? NOISE_TAPS : 32'd0);
    end
    return lfsr[15:0];
  endfunction

  // Gain and pan: round the magnitude, saturate to the signed 16-bit range
  function automatic logic [15:0] apply_gain(input logic signed [15:0] v,
                                             input logic [16:0] pan_scale);
    logic signed [31:0] w;
    logic [63:0]        mag;
    w   = v;
    mag = (w < 0) ? 64'(-w) : 64'(w);
    mag = mag * {48'd0, vol_r} * {47'd0, pan_scale};
    mag = (mag + (64'd1 << 30)) >> 31;
    if (w < 0) begin
      if (mag > 64'd32768) begin
        mag = 64'd32768;
      end
      return 16'(64'd0 - mag);
    end
    if (mag > 64'd32767) begin
      mag = 64'd32767;
    end
    return mag[15:0];
  endfunction

  // Work out the stereo word for one accepted input word
  task automatic predict_word(input logic buffer_start);
    logic [16:0]        p;
    logic signed [15:0] lv;
    logic signed [15:0] rv;
    logic signed [32:0] gap;
    logic [63:0]        mag;
    logic [63:0]        d;
    stereo_t            e;
    p = (pan_r > FULL_RIGHT) ? FULL_RIGHT : pan_r;
    if (noise_r) begin
      lv = next_noise();
      rv = next_noise();
    end else begin
      // glide the step 5% toward the target, at least one count
      if (buffer_start) begin
        gap = $signed({1'b0, target_r}) - $signed({1'b0, step});
        mag = (gap < 0) ? 64'(-gap) : 64'(gap);
        d   = (mag * GLIDE_GAIN + 64'd32768) >> 16;
        if (d == 0 && mag != 0) begin
          d = 64'd1;
        end
        step = (gap < 0) ? step - d[31:0] : step + d[31:0];
      end
      phase = phase + step;
      lv    = tone_value(phase & ({32{1'b1}} << (32 - TABLE_BITS)));
      rv    = lv;
    end
    e.left  = apply_gain(lv, 17'(FULL_RIGHT - p));
    e.right = apply_gain(rv, p);
    expected_samples.push_back(e);
  endtask

  task automatic flag(input string field, input logic [15:0] exp_v, input logic [15:0] got_v);
    errors++;
    $display("%0t: %s sample mismatch, expected %0d, got %0d",
             $time, field, $signed(exp_v), $signed(got_v));
  endtask

  initial begin
    errors      = 0;
    outstanding = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      vol_r    = VOLUME_RST;
      pan_r    = PAN_RST;
      target_r = 32'd0;
      noise_r  = 1'b0;
      phase    = 32'd0;
      step     = 32'd0;
      lfsr     = 32'd1;
      expected_samples.delete();
    end else begin
      // predict first: a word accepted with a write sees the old settings
      if (s_tvalid && s_tready) begin
        predict_word(s_tdata[0]);
      end
      // compare the arriving word with the oldest prediction
      if (m_tvalid && m_tready) begin
        if (expected_samples.size() == 0) begin
          errors++;
          $display("%0t: unexpected word, expected none, got left %0d right %0d",
                   $time, $signed(m_tdata[15:0]), $signed(m_tdata[31:16]));
        end else begin
          want = expected_samples.pop_front();
          if (m_tdata[15:0] !== want.left) begin
            flag("left", want.left, m_tdata[15:0]);
          end
          if (m_tdata[31:16] !== want.right) begin
            flag("right", want.right, m_tdata[31:16]);
          end
        end
      end
      // track register writes
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_VOLUME: vol_r    = pwdata[15:0];
          REG_PAN:    pan_r    = pwdata[16:0];
          REG_TARGET: target_r = pwdata;
          REG_NOISE:  noise_r  = pwdata[0];
          default: ;
        endcase
      end
    end
    outstanding = expected_samples.size();
  end

endmodule

[dv/stereo_sine_noise_synth_pan_tb.sv]
`timescale 1ns / 1ps
// Testbench top for stereo_sine_noise_synth_pan: drives registers and input
// words with random idling and back-pressure, and gives the verdict.
// Depends on ssnp_pkg, the block's RTL and synth_sample_checker.

module stereo_sine_noise_synth_pan_tb;
  import ssnp_pkg::*;

  localparam int STALL_LIMIT = 3000;
  localparam int HOLD_CYCLES = 150;
  localparam int PHASES      = 12;
  localparam int PHASE_WORDS = 115;

  logic                 clk;
  logic                 rst;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [APB_AW-1:0]    paddr;
  logic [31:0]          pwdata;
  logic [31:0]          prdata;
  logic                 pready;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [7:0]           s_tdata;
  logic                 m_tvalid;
  logic                 m_tready;
  logic [31:0]          m_tdata;

  int errors;
  int outstanding;
  int src_gap_pct;
  int snk_stall_pct;
  int quiet_cycles;
  bit hold_req;

  stereo_sine_noise_synth_pan dut (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  synth_sample_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .pready      (pready),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .errors      (errors),
    .outstanding (outstanding)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Receiver: random stalls, or a long hold-off on request
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= snk_stall_pct);
      end
    end
  end

  // One register write: setup cycle, then access until pready
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Offer one input word after a random gap and hold it until taken
  task automatic send_word(input logic buffer_start);
    @(negedge clk);
    while ($urandom_range(99) < src_gap_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {7'd0, buffer_start};
    do @(posedge clk); while (!s_tready);
  endtask

  // Drop valid and wait until every predicted word has come out
  task automatic wait_idle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  // Random settings, biased toward the extremes
  task automatic pick_settings();
    logic [31:0] vol;
    logic [31:0] pn;
    logic [31:0] tgt;
    case ($urandom_range(3))
      0:       vol = 32'd0;
      1:       vol = 32'd32768;
      2:       vol = 32'd65535;
      default: vol = $urandom_range(32768);
    endcase
    case ($urandom_range(3))
      0:       pn = 32'd0;
      1:       pn = 32'd65536;
      2:       pn = $urandom_range(131071, 65537);
      default: pn = $urandom_range(65536);
    endcase
    case ($urandom_range(3))
      0:       tgt = 32'hFFFF_FFFF;
      1:       tgt = $urandom;
      2:       tgt = $urandom_range(32'h0100_0000);
      default: tgt = 32'd0;
    endcase
    write_reg(REG_VOLUME, vol);
    write_reg(REG_PAN, pn);
    write_reg(REG_TARGET, tgt);
    write_reg(REG_NOISE, {31'd0, $urandom_range(3) == 0});
  endtask

  initial begin
    int bs_pct;
    rst           = 1'b1;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = 32'd0;
    s_tvalid      = 1'b0;
    s_tdata       = 8'd0;
    src_gap_pct   = 0;
    snk_stall_pct = 0;
    hold_req      = 1'b0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // reset settings: zero step, silent tone
    send_word(1'b1);
    send_word(1'b0);
    wait_idle();
    // tiny gap: the glide still moves the step by one
    write_reg(REG_TARGET, 32'd3);
    send_word(1'b1);
    send_word(1'b1);
    wait_idle();
    // full gain, hard left, glide toward the top increment
    write_reg(REG_VOLUME, 32'd65535);
    write_reg(REG_PAN, 32'd0);
    write_reg(REG_TARGET, 32'hFFFF_FFFF);
    repeat (4) send_word(1'b1);
    send_word(1'b0);
    wait_idle();
    // pan past full right, glide back down
    write_reg(REG_PAN, 32'd131071);
    write_reg(REG_TARGET, 32'd0);
    repeat (3) send_word(1'b1);
    send_word(1'b0);
    wait_idle();
    // muted, full right
    write_reg(REG_VOLUME, 32'd0);
    write_reg(REG_PAN, 32'd65536);
    send_word(1'b1);
    send_word(1'b0);
    wait_idle();
    // noise at unity gain; buffer starts are ignored
    write_reg(REG_VOLUME, 32'd32768);
    write_reg(REG_NOISE, 32'd1);
    send_word(1'b1);
    send_word(1'b0);
    send_word(1'b1);
    send_word(1'b0);
    send_word(1'b0);
    wait_idle();

    // random phases cycling through the idling modes
    for (int ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      pick_settings();
      case (ph % 4)
        0:       begin src_gap_pct = 0;  snk_stall_pct = 0;  end
        1:       begin src_gap_pct = 79; snk_stall_pct = 0;  end
        2:       begin src_gap_pct = 0;  snk_stall_pct = 79; end
        default: begin src_gap_pct = 37; snk_stall_pct = 37; end
      endcase
      bs_pct = $urandom_range(60, 5);
      for (int i = 0; i < PHASE_WORDS; i++) begin
        send_word($urandom_range(99) < bs_pct);
      end
    end

    // back-pressure: hold the output while the sender keeps offering
    wait_idle();
    pick_settings();
    src_gap_pct   = 0;
    snk_stall_pct = 0;
    hold_req      = 1'b1;
    repeat (40) send_word($urandom_range(3) == 0);
    // pause the sender until everything has drained, then resume
    wait_idle();
    repeat (20) send_word($urandom_range(3) == 0);

    wait_idle();
    snk_stall_pct = 0;
    repeat (20) @(negedge clk);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/ssnp_pkg.sv
rtl/ssnp_front.sv
rtl/ssnp_queue.sv
rtl/ssnp_gen.sv
rtl/ssnp_scale.sv
rtl/stereo_sine_noise_synth_pan.sv
rtl/ssnp_checker.sv
dv/synth_sample_checker.sv
dv/stereo_sine_noise_synth_pan_tb.sv
